// ===== hdl/abpw_pkg.sv =====
// ----------------------------------------------------------------------------
// abpw_pkg
// Shared types, constants and pixel helpers of the alpha blend pixel writer.
// ----------------------------------------------------------------------------
package abpw_pkg;

  localparam int MAX_STRIDE  = 512;
  localparam int MAX_ROWS    = 512;
  localparam int STORE_DEPTH = MAX_STRIDE * MAX_ROWS;
  localparam int OFFSET_W    = 18;
  localparam int COORD_W     = 12;
  localparam int DIM_W       = 10;
  localparam int CHAN_W      = 8;
  localparam int WORD_W      = 3 * CHAN_W;
  localparam int PROD_W      = 2 * DIM_W;
  localparam int FMT_W       = 2;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

  typedef logic [WORD_W-1:0]   pix_word_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [CHAN_W-1:0]   chan_t;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGB = 2'd0,
    FMT_BGR = 2'd1
  } fmt_t;

  typedef enum logic [1:0] {
    CFG_PIXEL_FORMAT   = 2'd0,
    CFG_VIEWPORT_WIDTH = 2'd1,
    CFG_SCREEN_HEIGHT  = 2'd2,
    CFG_ROW_STRIDE     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  function automatic pix_word_t pack_rgb(logic [FMT_W-1:0] fmt, rgb_t c);
    pix_word_t w;
    unique case (fmt_t'(fmt))
      FMT_RGB: w = {c.blue, c.green, c.red};
      FMT_BGR: w = {c.red, c.green, c.blue};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic rgb_t unpack_rgb(logic [FMT_W-1:0] fmt, pix_word_t w);
    rgb_t c;
    unique case (fmt_t'(fmt))
      FMT_RGB: c = '{red: w[7:0], green: w[15:8], blue: w[23:16]};
      FMT_BGR: c = '{red: w[23:16], green: w[15:8], blue: w[7:0]};
      default: c = '0;
    endcase
    return c;
  endfunction

  // floor((bg*(255-a) + fg*a) / 255), divide by reciprocal trick
  function automatic chan_t blend_ch(chan_t fg, chan_t bg, chan_t a);
    logic [2*CHAN_W-1:0] sum;
    logic [2*CHAN_W:0]   t;
    sum = (2*CHAN_W)'(bg) * (2*CHAN_W)'(ALPHA_OPAQUE - a)
        + (2*CHAN_W)'(fg) * (2*CHAN_W)'(a);
    t   = (2*CHAN_W+1)'(sum) + (2*CHAN_W+1)'(sum[2*CHAN_W-1:CHAN_W])
        + (2*CHAN_W+1)'(1);
    return t[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

// ===== hdl/alpha_blend_pixel_writer_unit.sv =====
// ----------------------------------------------------------------------------
// alpha_blend_pixel_writer_unit
// Pixel draw stream into a 24-bit draft store with alpha blending.
// ----------------------------------------------------------------------------
// channel | handshake           | payload
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_wdata
// in      | in_valid/in_stall   | x, y, red, green, blue, alpha
// out     | out_valid/out_stall | write_offset, pixel_word
//
// One draw beat per cycle while in_stall is low; a result passes from the
// s1 and s2 stage registers into the output register.
// The loop is read of the store, blend, write back,
// with the last write forwarded to the next read of the same offset.
// After reset a clearing pass zeroes the store with in_stall high. Apart
// from that pass, in_stall rises only while the output register holds a
// stalled beat and a draw sits in the blend stage.
// ----------------------------------------------------------------------------
module alpha_blend_pixel_writer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  abpw_pkg::cfg_reg_t              cfg_index,
  input  logic [abpw_pkg::DIM_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [abpw_pkg::COORD_W-1:0]    in_x_coord,
  input  logic [abpw_pkg::COORD_W-1:0]    in_y_coord,
  input  abpw_pkg::chan_t                 in_red,
  input  abpw_pkg::chan_t                 in_green,
  input  abpw_pkg::chan_t                 in_blue,
  input  abpw_pkg::chan_t                 in_alpha,
  output logic                            out_valid,
  input  logic                            out_stall,
  output abpw_pkg::offset_t               out_write_offset,
  output abpw_pkg::pix_word_t             out_pixel_word
);
  import abpw_pkg::*;

  localparam offset_t LAST_ADDR = OFFSET_W'(STORE_DEPTH - 1);

  logic [FMT_W-1:0] fmt_r;
  logic [DIM_W-1:0] vw_r;
  logic [DIM_W-1:0] sh_r;
  logic [DIM_W-1:0] stride_r;

  logic    clr_busy_r;
  offset_t clr_addr_r;

  logic              adv;
  logic              acc;
  logic              in_pass;
  logic              s1_vld_r;
  logic [DIM_W-1:0]  s1_x_r;
  logic [PROD_W-1:0] s1_prod_r;
  rgb_t              s1_col_r;
  chan_t             s1_a_r;
  offset_t           s1_off;

  logic    s2_vld_r;
  offset_t s2_off_r;
  rgb_t    s2_col_r;
  chan_t   s2_a_r;
  logic    s2_wr;

  pix_word_t store_mem [STORE_DEPTH];
  pix_word_t rd_data_r;
  logic      mem_we;
  offset_t   mem_waddr;
  pix_word_t mem_wdata;

  logic      wb_vld_r;
  offset_t   wb_off_r;
  pix_word_t wb_word_r;
  pix_word_t old_word;
  pix_word_t new_word;
  logic      changed;

  logic      out_valid_r;
  logic      out_valid_nxt;
  offset_t   out_off_r;
  pix_word_t out_word_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_RGB;
      vw_r     <= DIM_W'(MAX_STRIDE);
      sh_r     <= DIM_W'(MAX_ROWS);
      stride_r <= DIM_W'(MAX_STRIDE);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PIXEL_FORMAT:   fmt_r    <= cfg_wdata[FMT_W-1:0];
        CFG_VIEWPORT_WIDTH: vw_r     <= cfg_wdata;
        CFG_SCREEN_HEIGHT:  sh_r     <= cfg_wdata;
        CFG_ROW_STRIDE:     stride_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + OFFSET_W'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign adv      = ~(out_valid_r & out_stall & s2_vld_r);
  assign in_stall = clr_busy_r | ~adv;
  assign acc      = in_valid & ~in_stall;
  assign in_pass  = (in_x_coord < COORD_W'(vw_r)) && (in_y_coord < COORD_W'(sh_r))
                 && (in_alpha != ALPHA_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      wb_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= acc & in_pass;
      s2_vld_r <= s1_vld_r;
      wb_vld_r <= s2_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r    <= in_x_coord[DIM_W-1:0];
      s1_prod_r <= in_y_coord[DIM_W-1:0] * stride_r;
      s1_col_r  <= '{red: in_red, green: in_green, blue: in_blue};
      s1_a_r    <= in_alpha;
      s2_off_r  <= s1_off;
      s2_col_r  <= s1_col_r;
      s2_a_r    <= s1_a_r;
      wb_off_r  <= s2_off_r;
      wb_word_r <= new_word;
    end
  end

  assign s1_off = OFFSET_W'(s1_x_r) + s1_prod_r[OFFSET_W-1:0];

  assign mem_we    = clr_busy_r | s2_wr;
  assign mem_waddr = clr_busy_r ? clr_addr_r : s2_off_r;
  assign mem_wdata = clr_busy_r ? '0 : new_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (adv) begin
      rd_data_r <= store_mem[s1_off];
    end
  end

  assign old_word = (wb_vld_r && (wb_off_r == s2_off_r)) ? wb_word_r : rd_data_r;

  abpw_blend u_blend (
    .fmt      (fmt_r),
    .old_word (old_word),
    .red      (s2_col_r.red),
    .green    (s2_col_r.green),
    .blue     (s2_col_r.blue),
    .alpha    (s2_a_r),
    .new_word (new_word),
    .changed  (changed)
  );

  assign s2_wr = adv & s2_vld_r & changed;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s2_wr) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_wr) begin
      out_off_r  <= s2_off_r;
      out_word_r <= new_word;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_offset = out_off_r;
  assign out_pixel_word   = out_word_r;

endmodule

// ===== hdl/abpw_blend.sv =====
// ----------------------------------------------------------------------------
// abpw_blend
// Packs the new color, blends it over the stored word and flags a change.
// ----------------------------------------------------------------------------
module abpw_blend (
  input  logic [abpw_pkg::FMT_W-1:0] fmt,
  input  abpw_pkg::pix_word_t        old_word,
  input  abpw_pkg::chan_t            red,
  input  abpw_pkg::chan_t            green,
  input  abpw_pkg::chan_t            blue,
  input  abpw_pkg::chan_t            alpha,
  output abpw_pkg::pix_word_t        new_word,
  output logic                       changed
);
  import abpw_pkg::*;

  rgb_t      fg;
  rgb_t      bg;
  rgb_t      mix;
  pix_word_t fg_word;
  pix_word_t mix_word;

  always_comb begin
    fg        = '{red: red, green: green, blue: blue};
    bg        = unpack_rgb(fmt, old_word);
    mix.red   = blend_ch(fg.red,   bg.red,   alpha);
    mix.green = blend_ch(fg.green, bg.green, alpha);
    mix.blue  = blend_ch(fg.blue,  bg.blue,  alpha);
    fg_word   = pack_rgb(fmt, fg);
    mix_word  = pack_rgb(fmt, mix);
    if (fg_word == old_word) begin
      new_word = fg_word;
      changed  = 1'b0;
    end else begin
      new_word = (alpha == ALPHA_OPAQUE) ? fg_word : mix_word;
      changed  = (new_word != old_word);
    end
  end

endmodule
